// ----- rtl/core/hbrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hbrc_pkg;

	// store geometry
	localparam int NUM_BINS    = 1024;
	localparam int COUNT_WIDTH = 32;
	localparam int ADDR_W      = $clog2(NUM_BINS);

	// value and bin index widths
	localparam int VAL_W = 16;
	localparam int IDX_W = 17;

	// query sum, saturating
	localparam int SUM_W = 42;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam int ACC_W = ((SUM_W > COUNT_WIDTH) ? SUM_W : COUNT_WIDTH) + 1;

	// request codes
	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_QUERY = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// configuration register indexes
	localparam int CFG_W = 2;
	localparam logic [CFG_W-1:0] CFG_MIN   = 2'd0;
	localparam logic [CFG_W-1:0] CFG_MAX   = 2'd1;
	localparam logic [CFG_W-1:0] CFG_WIDTH = 2'd2;

	// divider steps, one quotient bit each
	localparam int DIV_STEPS = VAL_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] dividend;
		logic [VAL_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/hbrc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hbrc_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hbrc_pkg::div_req_t req,
	output hbrc_pkg::div_rsp_t     rsp
);

	logic [hbrc_pkg::VAL_W:0]           rem_q;
	logic [hbrc_pkg::VAL_W-1:0]         quo_q;
	logic [hbrc_pkg::VAL_W-1:0]         dvs_q;
	logic [hbrc_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic                               busy_q;
	logic                               done_q;
	logic [hbrc_pkg::VAL_W:0]           shifted;
	logic [hbrc_pkg::VAL_W:0]           dvs_ext;
	logic                               fits;

	// one restoring step: shift in the next dividend bit, trial subtract
	always_comb begin
		shifted = {rem_q[hbrc_pkg::VAL_W-1:0], quo_q[hbrc_pkg::VAL_W-1]};
		dvs_ext = {1'b0, dvs_q};
		fits    = (shifted >= dvs_ext);
	end

	// step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= hbrc_pkg::DIV_CNT_W'(hbrc_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q  <= cnt_q - 1'b1;
				busy_q <= (cnt_q != hbrc_pkg::DIV_CNT_W'(1));
				done_q <= (cnt_q == hbrc_pkg::DIV_CNT_W'(1));
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - dvs_ext) : shifted;
			quo_q <= {quo_q[hbrc_pkg::VAL_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

// ----- rtl/core/hbrc_bins.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hbrc_bins (
	input  wire logic                                clk,
	input  wire logic                                we,
	input  wire logic [hbrc_pkg::ADDR_W-1:0]         waddr,
	input  wire logic [hbrc_pkg::COUNT_WIDTH-1:0]    wdata,
	input  wire logic [hbrc_pkg::ADDR_W-1:0]         raddr,
	output logic      [hbrc_pkg::COUNT_WIDTH-1:0]    rdata
);

	logic [hbrc_pkg::COUNT_WIDTH-1:0] mem [hbrc_pkg::NUM_BINS];
	logic [hbrc_pkg::COUNT_WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/histogram_bin_and_range_count.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake             payload
// in        input      in_valid / in_ready   req_type, sample, range_low, range_high
// out       output     out_valid / out_ready pixel_count, accepted
// cfg       input      cfg_we                cfg_addr, cfg_data
//
// one item at a time; every divide goes through one shared divider: a start cycle,
// 16 quotient steps and a done cycle.
// add: a sample in range takes one divide, a bin read and a bin write before its result.
// query: up to three divides, then a walk that sums the bins in range, one bin a cycle.
// clear and reset sweep all NUM_BINS (1024) bins of the store to zero, one bin a cycle.
// in_ready is low during the reset sweep; a stalled result waits in the output
// register while the next item is already accepted.

module histogram_bin_and_range_count (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [1:0]                         req_type,
	input  wire logic signed [hbrc_pkg::VAL_W-1:0]  sample,
	input  wire logic signed [hbrc_pkg::VAL_W-1:0]  range_low,
	input  wire logic signed [hbrc_pkg::VAL_W-1:0]  range_high,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [hbrc_pkg::SUM_W-1:0]              pixel_count,
	output logic                                    accepted,
	input  wire logic                               cfg_we,
	input  wire logic [hbrc_pkg::CFG_W-1:0]         cfg_addr,
	input  wire logic [hbrc_pkg::VAL_W-1:0]         cfg_data
);

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_CHECK   = 4'd2;
	localparam logic [3:0] S_DIVGO   = 4'd3;
	localparam logic [3:0] S_DIVWAIT = 4'd4;
	localparam logic [3:0] S_HI_DEC  = 4'd5;
	localparam logic [3:0] S_ADD_RD  = 4'd6;
	localparam logic [3:0] S_ADD_WR  = 4'd7;
	localparam logic [3:0] S_WALK    = 4'd8;
	localparam logic [3:0] S_DONE    = 4'd9;

	localparam logic [1:0] SEL_SAMPLE = 2'd0;
	localparam logic [1:0] SEL_MAX    = 2'd1;
	localparam logic [1:0] SEL_LO     = 2'd2;
	localparam logic [1:0] SEL_HI     = 2'd3;

	localparam logic [hbrc_pkg::IDX_W-1:0] NBINS = hbrc_pkg::IDX_W'(hbrc_pkg::NUM_BINS);
	localparam logic [hbrc_pkg::ADDR_W-1:0] LAST_ADDR =
		hbrc_pkg::ADDR_W'(hbrc_pkg::NUM_BINS - 1);

	// configuration registers
	logic signed [hbrc_pkg::VAL_W-1:0] min_q;
	logic signed [hbrc_pkg::VAL_W-1:0] max_q;
	logic [hbrc_pkg::VAL_W-1:0]        width_q;

	// item registers
	logic [1:0]                        req_q;
	logic signed [hbrc_pkg::VAL_W-1:0] sample_q;
	logic signed [hbrc_pkg::VAL_W-1:0] lo_q;
	logic signed [hbrc_pkg::VAL_W-1:0] hi_q;

	// sequencer
	logic [3:0]                        state_q;
	logic [1:0]                        sel_q;
	logic                              resp_q;
	logic                              rv_q;
	logic [hbrc_pkg::IDX_W-1:0]        ptr_q;
	logic [hbrc_pkg::IDX_W-1:0]        end_q;
	logic [hbrc_pkg::IDX_W-1:0]        used_q;
	logic [hbrc_pkg::IDX_W-1:0]        idx_q;
	logic [hbrc_pkg::SUM_W-1:0]        sum_q;
	logic                              ok_q;

	// output register
	logic                              out_valid_q;
	logic [hbrc_pkg::SUM_W-1:0]        pixel_count_q;
	logic                              accepted_q;

	hbrc_pkg::div_req_t                div_req;
	hbrc_pkg::div_rsp_t                div_rsp;

	logic signed [hbrc_pkg::VAL_W-1:0] div_val;
	logic signed [hbrc_pkg::VAL_W:0]   div_diff;
	logic [hbrc_pkg::IDX_W-1:0]        q_ext;
	logic [hbrc_pkg::IDX_W-1:0]        q_inc;
	logic                              walk_more;

	logic                              mem_we;
	logic [hbrc_pkg::ADDR_W-1:0]       mem_waddr;
	logic [hbrc_pkg::COUNT_WIDTH-1:0]  mem_wdata;
	logic [hbrc_pkg::ADDR_W-1:0]       mem_raddr;
	logic [hbrc_pkg::COUNT_WIDTH-1:0]  mem_rdata;
	logic [hbrc_pkg::ACC_W-1:0]        acc;
	logic [hbrc_pkg::SUM_W-1:0]        sum_nxt;

	assign in_ready = (state_q == S_IDLE);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= '0;
			max_q   <= 16'sd100;
			width_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				hbrc_pkg::CFG_MIN:   min_q   <= cfg_data;
				hbrc_pkg::CFG_MAX:   max_q   <= cfg_data;
				hbrc_pkg::CFG_WIDTH: width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// divider operand: offset of the selected value from min
	always_comb begin
		unique case (sel_q)
			SEL_SAMPLE: div_val = sample_q;
			SEL_MAX:    div_val = max_q;
			SEL_LO:     div_val = lo_q;
			default:    div_val = hi_q;
		endcase
		div_diff         = {div_val[hbrc_pkg::VAL_W-1], div_val} -
		                   {min_q[hbrc_pkg::VAL_W-1], min_q};
		div_req.start    = (state_q == S_DIVGO);
		div_req.dividend = div_diff[hbrc_pkg::VAL_W-1:0];
		div_req.divisor  = width_q;
		q_ext            = {1'b0, div_rsp.quotient};
		q_inc            = q_ext + 1'b1;
	end

	hbrc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// bin store ports
	always_comb begin
		walk_more = (ptr_q < end_q);
		mem_we    = (state_q == S_CLEAR) || (state_q == S_ADD_WR);
		mem_waddr = (state_q == S_CLEAR) ? ptr_q[hbrc_pkg::ADDR_W-1:0]
		                                 : idx_q[hbrc_pkg::ADDR_W-1:0];
		if (state_q == S_CLEAR) begin
			mem_wdata = '0;
		end else if (mem_rdata == '1) begin
			mem_wdata = mem_rdata;
		end else begin
			mem_wdata = mem_rdata + 1'b1;
		end
		mem_raddr = (state_q == S_WALK) ? ptr_q[hbrc_pkg::ADDR_W-1:0]
		                                : idx_q[hbrc_pkg::ADDR_W-1:0];
		acc       = hbrc_pkg::ACC_W'(sum_q) + hbrc_pkg::ACC_W'(mem_rdata);
		sum_nxt   = (acc > hbrc_pkg::ACC_W'(hbrc_pkg::SUM_MAX)) ? hbrc_pkg::SUM_MAX
		                                                        : acc[hbrc_pkg::SUM_W-1:0];
	end

	hbrc_bins u_bins (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// item capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q    <= req_type;
			sample_q <= sample;
			lo_q     <= range_low;
			hi_q     <= range_high;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			sel_q   <= SEL_SAMPLE;
			resp_q  <= 1'b0;
			rv_q    <= 1'b0;
			ptr_q   <= '0;
			end_q   <= '0;
			used_q  <= '0;
			idx_q   <= '0;
			sum_q   <= '0;
			ok_q    <= 1'b0;
		end else begin
			unique case (state_q)
				// sweep every bin to zero
				S_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q[hbrc_pkg::ADDR_W-1:0] == LAST_ADDR) begin
						state_q <= resp_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						sum_q   <= '0;
						ok_q    <= 1'b0;
						state_q <= S_CHECK;
					end
				end
				// decide what the item needs
				S_CHECK: begin
					unique case (req_q)
						hbrc_pkg::REQ_ADD: begin
							if (width_q != '0 && sample_q >= min_q && sample_q <= max_q) begin
								sel_q   <= SEL_SAMPLE;
								state_q <= S_DIVGO;
							end else begin
								state_q <= S_DONE;
							end
						end
						hbrc_pkg::REQ_QUERY: begin
							if (width_q != '0 && max_q >= min_q) begin
								sel_q   <= SEL_MAX;
								state_q <= S_DIVGO;
							end else begin
								state_q <= S_DONE;
							end
						end
						hbrc_pkg::REQ_CLEAR: begin
							ptr_q   <= '0;
							resp_q  <= 1'b1;
							state_q <= S_CLEAR;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_DIVGO: state_q <= S_DIVWAIT;
				// take the quotient and move on
				S_DIVWAIT: begin
					if (div_rsp.done) begin
						unique case (sel_q)
							SEL_SAMPLE: begin
								if (q_ext < NBINS) begin
									idx_q   <= q_ext;
									state_q <= S_ADD_RD;
								end else begin
									state_q <= S_DONE;
								end
							end
							SEL_MAX: begin
								used_q <= (q_inc > NBINS) ? NBINS : q_inc;
								if (lo_q >= min_q) begin
									sel_q   <= SEL_LO;
									state_q <= S_DIVGO;
								end else begin
									ptr_q   <= '0;
									state_q <= S_HI_DEC;
								end
							end
							SEL_LO: begin
								ptr_q   <= q_ext;
								state_q <= S_HI_DEC;
							end
							default: begin
								end_q   <= (q_ext > used_q) ? used_q : q_ext;
								rv_q    <= 1'b0;
								state_q <= S_WALK;
							end
						endcase
					end
				end
				// end bin of the query
				S_HI_DEC: begin
					if (hi_q > max_q) begin
						end_q   <= used_q;
						rv_q    <= 1'b0;
						state_q <= S_WALK;
					end else if (hi_q < min_q) begin
						end_q   <= '0;
						rv_q    <= 1'b0;
						state_q <= S_WALK;
					end else begin
						sel_q   <= SEL_HI;
						state_q <= S_DIVGO;
					end
				end
				S_ADD_RD: state_q <= S_ADD_WR;
				S_ADD_WR: begin
					ok_q    <= 1'b1;
					state_q <= S_DONE;
				end
				// issue one bin read a cycle, sum its data in the cycle after the read
				S_WALK: begin
					if (walk_more) begin
						ptr_q <= ptr_q + 1'b1;
					end
					rv_q <= walk_more;
					if (rv_q) begin
						sum_q <= sum_nxt;
					end
					if (!walk_more && !rv_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						resp_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			pixel_count_q <= sum_q;
			accepted_q    <= ok_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_count = pixel_count_q;
	assign accepted    = accepted_q;

	// an add that lands never carries a sum
	a_add_no_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |-> (pixel_count == '0))
		else $error("accepted add with nonzero pixel_count");

	// divider finishes only while the sequencer waits on it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIVWAIT))
		else $error("divider done outside wait state");

	// an accepted item goes straight to the decision step
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_CHECK))
		else $error("accepted item did not reach check state");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	// block constants and codes
	localparam int VAL_W       = hbrc_pkg::VAL_W;
	localparam int SUM_W       = hbrc_pkg::SUM_W;
	localparam int COUNT_WIDTH = hbrc_pkg::COUNT_WIDTH;
	localparam int NUM_BINS    = hbrc_pkg::NUM_BINS;
	localparam int CFG_W       = hbrc_pkg::CFG_W;
	localparam logic [SUM_W-1:0] SUM_MAX = hbrc_pkg::SUM_MAX;
	localparam logic [1:0] REQ_ADD   = hbrc_pkg::REQ_ADD;
	localparam logic [1:0] REQ_QUERY = hbrc_pkg::REQ_QUERY;
	localparam logic [1:0] REQ_CLEAR = hbrc_pkg::REQ_CLEAR;
	localparam logic [CFG_W-1:0] CFG_MIN   = hbrc_pkg::CFG_MIN;
	localparam logic [CFG_W-1:0] CFG_MAX   = hbrc_pkg::CFG_MAX;
	localparam logic [CFG_W-1:0] CFG_WIDTH = hbrc_pkg::CFG_WIDTH;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic signed [VAL_W-1:0] V_LOW  = 16'sh8000;
	localparam logic signed [VAL_W-1:0] V_HIGH = 16'sh7fff;
	localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = '1;
	localparam int IDLE_MAX = 14;
	localparam int STALL_LIMIT = 8000;

	typedef struct packed {
		logic [SUM_W-1:0] count;
		logic             ok;
	} result_t;

	// one directed item; cnt and ok are used only where typed is set
	typedef struct packed {
		logic [1:0]       req;
		logic [VAL_W-1:0] smp;
		logic [VAL_W-1:0] lo;
		logic [VAL_W-1:0] hi;
		logic             typed;
		logic [SUM_W-1:0] cnt;
		logic             ok;
	} probe_row_t;

	// one register setting and how many random items run under it
	typedef struct packed {
		logic [VAL_W-1:0] mn;
		logic [VAL_W-1:0] mx;
		logic [VAL_W-1:0] wd;
		logic [15:0]      items;
	} setting_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [1:0]              req_type = REQ_ADD;
	logic signed [VAL_W-1:0] sample = '0;
	logic signed [VAL_W-1:0] range_low = '0;
	logic signed [VAL_W-1:0] range_high = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [SUM_W-1:0]        pixel_count;
	logic                    accepted;
	logic                    cfg_we = 1'b0;
	logic [CFG_W-1:0]        cfg_addr = CFG_MIN;
	logic [VAL_W-1:0]        cfg_data = '0;

	// shadow copy of the block: bins and registers
	logic [COUNT_WIDTH-1:0]  shadow_bins [NUM_BINS];
	logic signed [VAL_W-1:0] cfg_min = 16'sd0;
	logic signed [VAL_W-1:0] cfg_max = 16'sd100;
	logic [VAL_W-1:0]        cfg_width = 16'd1;

	result_t pending_results [$];
	int      mismatches = 0;
	int      stall_cycles = 0;

	// directed items, walked after reset under the reset settings
	probe_row_t probe_rows [23] = '{
		'{REQ_QUERY, 16'sd0, 16'sd0, 16'sd100, 1'b1, 42'd0, 1'b0},
		'{REQ_ADD, 16'sd0, 16'sd0, 16'sd0, 1'b1, 42'd0, 1'b1},
		'{REQ_ADD, 16'sd100, 16'sd0, 16'sd0, 1'b1, 42'd0, 1'b1},
		'{REQ_ADD, -16'sd1, 16'sd0, 16'sd0, 1'b1, 42'd0, 1'b0},
		'{REQ_ADD, 16'sd101, 16'sd0, 16'sd0, 1'b1, 42'd0, 1'b0},
		'{REQ_ADD, V_LOW, 16'sd0, 16'sd0, 1'b1, 42'd0, 1'b0},
		'{REQ_ADD, V_HIGH, 16'sd0, 16'sd0, 1'b1, 42'd0, 1'b0},
		'{REQ_ADD, 16'sd50, 16'sd0, 16'sd0, 1'b1, 42'd0, 1'b1},
		'{REQ_ADD, 16'sd50, 16'sd0, 16'sd0, 1'b1, 42'd0, 1'b1},
		'{REQ_QUERY, 16'sd0, 16'sd0, 16'sd101, 1'b0, 42'd0, 1'b0},
		'{REQ_QUERY, 16'sd0, V_LOW, V_HIGH, 1'b0, 42'd0, 1'b0},
		'{REQ_QUERY, 16'sd0, 16'sd50, 16'sd50, 1'b1, 42'd0, 1'b0},
		'{REQ_QUERY, 16'sd0, 16'sd50, 16'sd51, 1'b0, 42'd0, 1'b0},
		'{REQ_QUERY, 16'sd0, 16'sd100, 16'sd0, 1'b1, 42'd0, 1'b0},
		'{REQ_QUERY, 16'sd0, V_HIGH, V_HIGH, 1'b1, 42'd0, 1'b0},
		'{REQ_QUERY, 16'sd0, 16'sd0, -16'sd1, 1'b1, 42'd0, 1'b0},
		'{REQ_UNUSED, 16'hffff, 16'hffff, 16'hffff, 1'b1, 42'd0, 1'b0},
		'{REQ_CLEAR, 16'sd0, 16'sd0, 16'sd0, 1'b1, 42'd0, 1'b0},
		'{REQ_QUERY, 16'sd0, V_LOW, V_HIGH, 1'b1, 42'd0, 1'b0},
		'{REQ_ADD, 16'sd100, 16'sd0, 16'sd0, 1'b1, 42'd0, 1'b1},
		'{REQ_QUERY, 16'sd0, 16'sd0, V_HIGH, 1'b0, 42'd0, 1'b0},
		'{REQ_QUERY, 16'sd0, V_LOW, V_LOW, 1'b1, 42'd0, 1'b0},
		'{REQ_ADD, 16'sd99, 16'sd0, 16'sd0, 1'b1, 42'd0, 1'b1}
	};

	// fixed settings: reset values, full span, widest bins, inverted range,
	// a single value, zero width and a few ordinary ones
	setting_t settings [10] = '{
		'{16'sd0, 16'sd100, 16'd1, 16'd150},
		'{V_LOW, V_HIGH, 16'd1, 16'd120},
		'{V_LOW, V_HIGH, 16'hffff, 16'd150},
		'{V_HIGH, V_LOW, 16'd7, 16'd60},
		'{16'sd10, 16'sd10, 16'd1, 16'd100},
		'{-16'sd50, 16'sd200, 16'd3, 16'd250},
		'{16'sd0, 16'sd100, 16'd0, 16'd50},
		'{-16'sd1000, 16'sd1000, 16'd5, 16'd180},
		'{16'sd100, 16'sd5000, 16'd16, 16'd180},
		'{-16'sd300, -16'sd20, 16'd1, 16'd180}
	};

	histogram_bin_and_range_count dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.sample     (sample),
		.range_low  (range_low),
		.range_high (range_high),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_count(pixel_count),
		.accepted   (accepted),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data)
	);

	// clock
	always #1 clk = ~clk;

	// bin holding value v; caller makes sure v >= min and width is nonzero
	function automatic int unsigned bin_index(input int v);
		int unsigned diff;
		diff = v - int'(cfg_min);
		return diff / cfg_width;
	endfunction

	function automatic int unsigned bins_used();
		int unsigned n;
		if (cfg_width == 0 || cfg_max < cfg_min)
			return 0;
		n = bin_index(cfg_max) + 1;
		return (n > NUM_BINS) ? NUM_BINS : n;
	endfunction

	// update the shadow bins for one item and work out its result
	task automatic apply_request(input logic [1:0] req, input logic signed [VAL_W-1:0] smp,
			input logic signed [VAL_W-1:0] lo, input logic signed [VAL_W-1:0] hi,
			output result_t res);
		int unsigned idx;
		int unsigned used;
		int unsigned first;
		int unsigned last;
		longint unsigned total;
		res = '0;
		total = 0;
		case (req)
			REQ_ADD: begin
				if (cfg_width != 0 && smp >= cfg_min && smp <= cfg_max) begin
					idx = bin_index(smp);
					if (idx < NUM_BINS) begin
						if (shadow_bins[idx] != COUNT_FULL)
							shadow_bins[idx] = shadow_bins[idx] + 1'b1;
						res.ok = 1'b1;
					end
				end
			end
			REQ_QUERY: begin
				used = bins_used();
				if (used != 0) begin
					first = (lo >= cfg_min) ? bin_index(lo) : 0;
					if (hi > cfg_max)
						last = used;
					else if (hi < cfg_min)
						last = 0;
					else
						last = bin_index(hi);
					if (last > used)
						last = used;
					for (int unsigned i = first; i < last; i++) begin
						total += shadow_bins[i];
						if (total > SUM_MAX)
							total = SUM_MAX;
					end
				end
				res.count = total[SUM_W-1:0];
			end
			REQ_CLEAR: begin
				for (int i = 0; i < NUM_BINS; i++)
					shadow_bins[i] = '0;
			end
			default: ;
		endcase
	endtask

	// value mostly near the bins in use, sometimes anywhere
	function automatic logic [VAL_W-1:0] pick_value();
		longint a;
		longint b;
		longint w;
		longint lo_l;
		longint hi_l;
		if ($urandom_range(0, 4) == 0)
			return VAL_W'($urandom);
		a = (cfg_min < cfg_max) ? cfg_min : cfg_max;
		b = (cfg_min < cfg_max) ? cfg_max : cfg_min;
		w = (cfg_width == 0) ? 4 : cfg_width;
		lo_l = a - 2 * w - 2;
		hi_l = a + w * (NUM_BINS + 2);
		if (hi_l > b + 2 * w + 2)
			hi_l = b + 2 * w + 2;
		if (lo_l < -32768)
			lo_l = -32768;
		if (hi_l > 32767)
			hi_l = 32767;
		return VAL_W'(lo_l + $urandom_range(0, int'(hi_l - lo_l)));
	endfunction

	// present one item, hold it until taken, then record what it should give
	bit in_idle_on = 1'b1;
	task automatic send_item(input logic [1:0] req, input logic [VAL_W-1:0] smp,
			input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi,
			input logic typed, input logic [SUM_W-1:0] t_cnt, input logic t_ok);
		int gap;
		result_t res;
		if ($urandom_range(0, 39) == 0)
			in_idle_on = !in_idle_on;
		gap = in_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		req_type   <= req;
		sample     <= smp;
		range_low  <= lo;
		range_high <= hi;
		do @(posedge clk); while (!in_ready);
		apply_request(req, smp, lo, hi, res);
		if (typed) begin
			res.count = t_cnt;
			res.ok    = t_ok;
		end
		pending_results = {pending_results, res};
	endtask

	// wait until the block has handed back everything and takes items again
	task automatic settle();
		while (pending_results.size() != 0)
			@(posedge clk);
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input logic [CFG_W-1:0] addr, input logic [VAL_W-1:0] value);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= value;
		case (addr)
			CFG_MIN:   cfg_min = value;
			CFG_MAX:   cfg_max = value;
			CFG_WIDTH: cfg_width = value;
			default: ;
		endcase
	endtask

	// new settings, then a run of random items under them
	task automatic run_phase(input logic [VAL_W-1:0] mn, input logic [VAL_W-1:0] mx,
			input logic [VAL_W-1:0] wd, input int items);
		int pick;
		logic [1:0] req;
		settle();
		write_reg(CFG_MIN, mn);
		write_reg(CFG_MAX, mx);
		write_reg(CFG_WIDTH, wd);
		@(negedge clk);
		cfg_we <= 1'b0;
		repeat (items) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				req = REQ_ADD;
			else if (pick < 94)
				req = REQ_QUERY;
			else if (pick < 98)
				req = REQ_CLEAR;
			else
				req = REQ_UNUSED;
			send_item(req, pick_value(), pick_value(), pick_value(), 1'b0, '0, 1'b0);
		end
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// stimulus
	initial begin : stimulus
		logic signed [VAL_W-1:0] r_min;
		longint r_max;
		logic [VAL_W-1:0] r_width;
		for (int i = 0; i < NUM_BINS; i++)
			shadow_bins[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (probe_rows[i])
			send_item(probe_rows[i].req, probe_rows[i].smp, probe_rows[i].lo,
				probe_rows[i].hi, probe_rows[i].typed, probe_rows[i].cnt, probe_rows[i].ok);
		@(negedge clk);
		in_valid <= 1'b0;

		foreach (settings[i])
			run_phase(settings[i].mn, settings[i].mx, settings[i].wd, settings[i].items);

		// random settings with a moderate number of bins
		repeat (3) begin
			r_min   = VAL_W'($urandom);
			r_width = VAL_W'($urandom_range(1, 64));
			r_max   = longint'(r_min) + $urandom_range(0, 300 * r_width);
			if (r_max > 32767)
				r_max = 32767;
			run_phase(r_min, VAL_W'(r_max), r_width, 60);
		end

		settle();
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// result side: stall at random, then compare with the oldest expectation
	initial begin : result_sink
		int stall;
		bit out_idle_on;
		result_t want;
		out_idle_on = 1'b1;
		forever begin
			if ($urandom_range(0, 39) == 0)
				out_idle_on = !out_idle_on;
			stall = out_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
			if (stall > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				do @(posedge clk); while (!out_valid);
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_results.size() == 0) begin
				$display("%0t: item out with nothing pending: pixel_count %0d accepted %0d",
					$time, pixel_count, accepted);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (pixel_count !== want.count) begin
					$display("%0t: pixel_count expected %0d got %0d",
						$time, want.count, pixel_count);
					mismatches++;
				end
				if (accepted !== want.ok) begin
					$display("%0t: accepted expected %0d got %0d", $time, want.ok, accepted);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

endmodule

// ----- filelist.f -----
rtl/core/hbrc_pkg.sv
rtl/core/hbrc_div.sv
rtl/core/hbrc_bins.sv
rtl/core/histogram_bin_and_range_count.sv
tb/tb_top.sv
